FILE: rtl/core/ust_pkg.sv
// Package for the UDP socket table engine: sizes, operation and status codes.
// No dependencies.
package ust_pkg;
  localparam int NSLOT = 16;
  localparam int SLOT_W = 4;
  localparam int QDEPTH = 8;
  localparam int QPOS_W = 3;
  localparam int CNT_W = 4;
  localparam logic [15:0] MAX_DGRAM = 16'd1472;
  localparam logic [23:0] GEN_MAX = 24'hffffff;
  localparam logic [15:0] TMO_MAX = 16'd10000;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0, OP_BIND = 3'd1, OP_CLOSE = 3'd2, OP_CLEANUP = 3'd3,
    OP_INGRESS = 3'd4, OP_RECV = 3'd5, OP_SEND = 3'd6, OP_STATS = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_INVALID = 4'd1, ST_BAD_HANDLE = 4'd2, ST_NO_SLOT = 4'd3,
    ST_PORT_USED = 4'd4, ST_UNBOUND = 4'd5, ST_QUEUE_FULL = 4'd6,
    ST_NO_LISTENER = 4'd7, ST_EMPTY = 4'd8, ST_TOO_SMALL = 4'd9
  } status_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
  } desc_t;
endpackage

FILE: rtl/core/ust_desc_ram.sv
// Descriptor store: one write and one registered read per cycle.
// Depends on ust_pkg.
module ust_desc_ram (
  input  logic                  clk,
  input  logic                  we,
  input  logic [6:0]            waddr,
  input  ust_pkg::desc_t        wdata,
  input  logic [6:0]            raddr,
  output ust_pkg::desc_t        rdata
);
  import ust_pkg::*;
  desc_t mem [0:NSLOT*QDEPTH-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/udp_socket_table_engine_top.sv
// UDP socket table engine top: slot table, slot-scan sequencer, descriptor RAM.
// Each request runs a scan of every slot, one slot per cycle, an action state, then the
// RAM read states (S_RD, S_RD2) on receive or padding (S_DONE) otherwise. The receiver
// cannot stall. busy drops in the done cycle; a new request is not taken until the
// last one is done.
// Reset clears all slot state and the drop counter; descriptors need no clear.
module udp_socket_table_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  op,
  input  logic [15:0] proc_id,
  input  logic [31:0] process_gen,
  input  logic [31:0] handle,
  input  logic [15:0] port,
  input  logic [31:0] remote_ip,
  input  logic [15:0] remote_port,
  input  logic [15:0] length,
  input  logic [15:0] capacity,
  input  logic [15:0] send_tmo,
  output logic [3:0]  status,
  output logic [31:0] new_handle,
  output logic [3:0]  slot_index,
  output logic [2:0]  queue_pos,
  output logic [31:0] peer_ip,
  output logic [15:0] peer_port,
  output logic [15:0] local_port_out,
  output logic [15:0] length_out,
  output logic [4:0]  active_count,
  output logic [7:0]  queued_count,
  output logic [31:0] dropped_count
);
  import ust_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_ACT = 6'b000100,
    S_RD = 6'b001000, S_RD2 = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t state;
  logic [SLOT_W:0] idx;
  logic [4:0] wait_cnt;

  logic        act  [NSLOT];
  logic [23:0] sgen [NSLOT];
  logic [15:0] spid [NSLOT];
  logic [31:0] sog  [NSLOT];
  logic [15:0] sport[NSLOT];
  logic [QPOS_W-1:0] rhead [NSLOT];
  logic [CNT_W-1:0]  rcnt  [NSLOT];
  logic [31:0] dropped;

  // latched request
  op_t r_op;
  logic [15:0] r_pid, r_port, r_rport, r_len, r_cap, r_tmo;
  logic [31:0] r_pgen, r_h, r_rip;

  // scan results
  logic found;
  logic [SLOT_W-1:0] fslot;
  logic used;
  logic [4:0] nact;
  logic [7:0] nq;

  // handle check (single selected slot)
  logic [SLOT_W-1:0] hs;
  logic hok;
  logic [7:0] hlow;
  assign hlow = r_h[7:0];
  assign hs = SLOT_W'(hlow - 8'd1);
  assign hok = hlow != 8'd0 && hlow <= 8'(NSLOT) && r_h[31:8] != 24'd0 &&
               act[hs] && sgen[hs] == r_h[31:8] && spid[hs] == r_pid &&
               sog[hs] == r_pgen;

  logic [SLOT_W-1:0] cs;
  assign cs = idx[SLOT_W-1:0];

  logic ram_we;
  logic [6:0] ram_wa, ram_ra;
  desc_t ram_wd, ram_rd;
  ust_desc_ram u_ram (.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
                      .raddr(ram_ra), .rdata(ram_rd));

  logic [QPOS_W-1:0] tail;
  assign tail = QPOS_W'(rhead[fslot] + rcnt[fslot][QPOS_W-1:0]);
  assign ram_wa = {fslot, tail};
  assign ram_wd = '{ip: r_rip, sport: r_rport, dport: r_port, len: r_len};
  assign ram_ra = {hs, rhead[hs]};
  assign ram_we = state == S_ACT && r_op == OP_INGRESS && found &&
                  rcnt[fslot] != CNT_W'(QDEPTH) && r_rip != 0 && r_rport != 0 &&
                  r_port != 0 && r_len <= MAX_DGRAM;

  assign busy = state != S_IDLE;

  logic [23:0] ngen;
  assign ngen = (sgen[fslot] == GEN_MAX) ? 24'd1 : sgen[fslot] + 24'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      dropped <= '0;
      idx <= '0;
      wait_cnt <= '0;
      for (int i = 0; i < NSLOT; i++) begin
        act[i] <= 1'b0; sgen[i] <= '0; spid[i] <= '0; sog[i] <= '0;
        sport[i] <= '0; rhead[i] <= '0; rcnt[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r_op <= op_t'(op); r_pid <= proc_id; r_pgen <= process_gen;
            r_h <= handle; r_port <= port; r_rip <= remote_ip;
            r_rport <= remote_port; r_len <= length; r_cap <= capacity;
            r_tmo <= send_tmo;
            idx <= '0; found <= 1'b0; fslot <= '0; used <= 1'b0;
            nact <= '0; nq <= '0; wait_cnt <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // visit one slot per cycle
          unique case (r_op)
            OP_OPEN: if (!found && !act[cs]) begin
              found <= 1'b1; fslot <= cs;
            end
            OP_BIND: if (act[cs] && sport[cs] == r_port && cs != hs) used <= 1'b1;
            OP_CLEANUP: if (act[cs] && spid[cs] == r_pid && sog[cs] == r_pgen) begin
              act[cs] <= 1'b0; spid[cs] <= '0; sog[cs] <= '0;
              sport[cs] <= '0; rhead[cs] <= '0; rcnt[cs] <= '0;
            end
            OP_INGRESS: if (!found && act[cs] && sport[cs] == r_port) begin
              found <= 1'b1; fslot <= cs;
            end
            OP_STATS: if (act[cs]) begin
              nact <= nact + 5'd1;
              nq <= nq + 8'(rcnt[cs]);
            end
            default: ;
          endcase
          if (idx == (SLOT_W+1)'(NSLOT - 1)) state <= S_ACT;
          idx <= idx + 1'b1;
        end
        S_ACT: begin
          status <= ST_OK; new_handle <= '0; slot_index <= '0; queue_pos <= '0;
          peer_ip <= '0; peer_port <= '0; local_port_out <= '0; length_out <= '0;
          active_count <= '0; queued_count <= '0; dropped_count <= '0;
          state <= S_DONE;
          unique case (r_op)
            OP_OPEN: begin
              if (r_pid == 0 || r_pgen == 0) status <= ST_INVALID;
              else if (!found) status <= ST_NO_SLOT;
              else begin
                act[fslot] <= 1'b1; sgen[fslot] <= ngen; spid[fslot] <= r_pid;
                sog[fslot] <= r_pgen; sport[fslot] <= '0;
                rhead[fslot] <= '0; rcnt[fslot] <= '0;
                new_handle <= {ngen, 4'd0, fslot} + 32'd1;
              end
            end
            OP_BIND: begin
              if (r_port == 0) status <= ST_INVALID;
              else if (!hok) status <= ST_BAD_HANDLE;
              else if (used) status <= ST_PORT_USED;
              else if (sport[hs] != 0 && sport[hs] != r_port) status <= ST_INVALID;
              else sport[hs] <= r_port;
            end
            OP_CLOSE: begin
              if (!hok) status <= ST_BAD_HANDLE;
              else begin
                act[hs] <= 1'b0; spid[hs] <= '0; sog[hs] <= '0;
                sport[hs] <= '0; rhead[hs] <= '0; rcnt[hs] <= '0;
              end
            end
            OP_CLEANUP: ;
            OP_INGRESS: begin
              if (r_rip == 0 || r_rport == 0 || r_port == 0 || r_len > MAX_DGRAM)
                status <= ST_INVALID;
              else if (!found) status <= ST_NO_LISTENER;
              else begin
                slot_index <= fslot;
                if (rcnt[fslot] == CNT_W'(QDEPTH)) begin
                  status <= ST_QUEUE_FULL;
                  if (dropped != 32'hffffffff) dropped <= dropped + 32'd1;
                end else begin
                  queue_pos <= tail;
                  rcnt[fslot] <= rcnt[fslot] + 1'b1;
                end
              end
            end
            OP_RECV: begin
              if (!hok) status <= ST_BAD_HANDLE;
              else if (rcnt[hs] == 0) status <= ST_EMPTY;
              else state <= S_RD;
            end
            OP_SEND: begin
              if (r_rip == 0 || r_rport == 0 || r_len > MAX_DGRAM || r_tmo > TMO_MAX)
                status <= ST_INVALID;
              else if (!hok) status <= ST_BAD_HANDLE;
              else if (sport[hs] == 0) status <= ST_UNBOUND;
              else local_port_out <= sport[hs];
            end
            OP_STATS: begin
              active_count <= nact; queued_count <= nq; dropped_count <= dropped;
            end
            default: ;
          endcase
        end
        S_RD: state <= S_RD2;   // RAM read in flight
        S_RD2: begin
          if (r_cap < ram_rd.len) status <= ST_TOO_SMALL;
          else begin
            slot_index <= hs; queue_pos <= rhead[hs];
            peer_ip <= ram_rd.ip; peer_port <= ram_rd.sport;
            local_port_out <= ram_rd.dport; length_out <= ram_rd.len;
            rhead[hs] <= rhead[hs] + 1'b1;
            rcnt[hs] <= rcnt[hs] - 1'b1;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_DONE: begin
          // pad to fixed latency
          if (wait_cnt == 5'd1) begin
            done <= 1'b1; state <= S_IDLE;
          end
          wait_cnt <= wait_cnt + 5'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: verif/ust_checker.sv
// Checker for the UDP socket table engine: watches the request and result ports,
// predicts every result from its own copy of the slot table and compares the whole result.
// Depends on ust_pkg.
module ust_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        done,
  input  logic [2:0]  op,
  input  logic [15:0] proc_id,
  input  logic [31:0] process_gen,
  input  logic [31:0] handle,
  input  logic [15:0] port,
  input  logic [31:0] remote_ip,
  input  logic [15:0] remote_port,
  input  logic [15:0] length,
  input  logic [15:0] capacity,
  input  logic [15:0] send_tmo,
  input  logic [3:0]  status,
  input  logic [31:0] new_handle,
  input  logic [3:0]  slot_index,
  input  logic [2:0]  queue_pos,
  input  logic [31:0] peer_ip,
  input  logic [15:0] peer_port,
  input  logic [15:0] local_port_out,
  input  logic [15:0] length_out,
  input  logic [4:0]  active_count,
  input  logic [7:0]  queued_count,
  input  logic [31:0] dropped_count,
  output int          fail_count,
  output int          pending
);
  import ust_pkg::*;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] new_handle;
    logic [3:0]  slot_index;
    logic [2:0]  queue_pos;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] local_port_out;
    logic [15:0] length_out;
    logic [4:0]  active_count;
    logic [7:0]  queued_count;
    logic [31:0] dropped_count;
  } socket_result_t;

  logic        sk_active [NSLOT];
  logic [23:0] sk_gen    [NSLOT];
  logic [15:0] sk_pid    [NSLOT];
  logic [31:0] sk_pgen   [NSLOT];
  logic [15:0] sk_port   [NSLOT];
  logic [2:0]  sk_head   [NSLOT];
  logic [3:0]  sk_count  [NSLOT];
  desc_t       dgram     [NSLOT][QDEPTH];
  logic [31:0] drop_total;

  socket_result_t awaited_results[$];

  function automatic int owned_slot(logic [15:0] pid, logic [31:0] pgen, logic [31:0] h);
    int s;
    if (h[7:0] == 8'd0 || h[7:0] > NSLOT || h[31:8] == 24'd0) return -1;
    s = h[7:0] - 1;
    if (!sk_active[s] || sk_gen[s] != h[31:8] || sk_pid[s] != pid || sk_pgen[s] != pgen)
      return -1;
    return s;
  endfunction

  function automatic void free_slot(int s);
    sk_active[s] = 1'b0;
    sk_pid[s] = '0;
    sk_pgen[s] = '0;
    sk_port[s] = '0;
    sk_head[s] = '0;
    sk_count[s] = '0;
  endfunction

  task automatic predict_socket_op();
    socket_result_t r;
    int k;
    int s;
    logic hit;
    logic [23:0] g;
    logic [2:0] tail;
    r = '0;
    r.status = ST_OK;
    case (op_t'(op))
      OP_OPEN: begin
        if (proc_id == 0 || process_gen == 0) r.status = ST_INVALID;
        else begin
          r.status = ST_NO_SLOT;
          hit = 1'b0;
          for (s = 0; s < NSLOT; s++) begin
            if (!hit && !sk_active[s]) begin
              hit = 1'b1;
              g = (sk_gen[s] == GEN_MAX) ? 24'd1 : sk_gen[s] + 24'd1;
              free_slot(s);
              sk_active[s] = 1'b1;
              sk_gen[s] = g;
              sk_pid[s] = proc_id;
              sk_pgen[s] = process_gen;
              r.new_handle = {g, 8'(s + 1)};
              r.status = ST_OK;
            end
          end
        end
      end
      OP_BIND: begin
        k = owned_slot(proc_id, process_gen, handle);
        if (port == 0) r.status = ST_INVALID;
        else if (k < 0) r.status = ST_BAD_HANDLE;
        else begin
          for (s = 0; s < NSLOT; s++)
            if (s != k && sk_active[s] && sk_port[s] == port) r.status = ST_PORT_USED;
          if (r.status == ST_OK) begin
            if (sk_port[k] != 0 && sk_port[k] != port) r.status = ST_INVALID;
            else sk_port[k] = port;
          end
        end
      end
      OP_CLOSE: begin
        k = owned_slot(proc_id, process_gen, handle);
        if (k < 0) r.status = ST_BAD_HANDLE;
        else free_slot(k);
      end
      OP_CLEANUP: begin
        for (s = 0; s < NSLOT; s++)
          if (sk_active[s] && sk_pid[s] == proc_id && sk_pgen[s] == process_gen)
            free_slot(s);
      end
      OP_INGRESS: begin
        if (remote_ip == 0 || remote_port == 0 || port == 0 || length > MAX_DGRAM)
          r.status = ST_INVALID;
        else begin
          r.status = ST_NO_LISTENER;
          hit = 1'b0;
          for (s = 0; s < NSLOT; s++) begin
            if (!hit && sk_active[s] && sk_port[s] == port) begin
              hit = 1'b1;
              r.slot_index = SLOT_W'(s);
              if (sk_count[s] >= QDEPTH) begin
                if (drop_total != 32'hffffffff) drop_total++;
                r.status = ST_QUEUE_FULL;
              end else begin
                tail = sk_head[s] + 3'(sk_count[s]);
                dgram[s][tail] = '{ip: remote_ip, sport: remote_port, dport: port,
                                   len: length};
                sk_count[s]++;
                r.queue_pos = tail;
                r.status = ST_OK;
              end
            end
          end
        end
      end
      OP_RECV: begin
        k = owned_slot(proc_id, process_gen, handle);
        if (k < 0) r.status = ST_BAD_HANDLE;
        else if (sk_count[k] == 0) r.status = ST_EMPTY;
        else if (capacity < dgram[k][sk_head[k]].len) r.status = ST_TOO_SMALL;
        else begin
          r.slot_index = SLOT_W'(k);
          r.queue_pos = sk_head[k];
          r.peer_ip = dgram[k][sk_head[k]].ip;
          r.peer_port = dgram[k][sk_head[k]].sport;
          r.local_port_out = dgram[k][sk_head[k]].dport;
          r.length_out = dgram[k][sk_head[k]].len;
          sk_head[k]++;
          sk_count[k]--;
        end
      end
      OP_SEND: begin
        k = owned_slot(proc_id, process_gen, handle);
        if (remote_ip == 0 || remote_port == 0 || length > MAX_DGRAM || send_tmo > TMO_MAX)
          r.status = ST_INVALID;
        else if (k < 0) r.status = ST_BAD_HANDLE;
        else if (sk_port[k] == 0) r.status = ST_UNBOUND;
        else r.local_port_out = sk_port[k];
      end
      default: begin
        for (s = 0; s < NSLOT; s++)
          if (sk_active[s]) begin
            r.active_count++;
            r.queued_count += sk_count[s];
          end
        r.dropped_count = drop_total;
      end
    endcase
    awaited_results.push_back(r);
  endtask

  task automatic check_result();
    socket_result_t want;
    socket_result_t got;
    got = '{status, new_handle, slot_index, queue_pos, peer_ip, peer_port, local_port_out,
            length_out, active_count, queued_count, dropped_count};
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, got %h", $realtime, got);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        $display("%0t: result differs, expected %h, actual %h", $realtime, want, got);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSLOT; s++) begin
        free_slot(s);
        sk_gen[s] = '0;
      end
      drop_total = '0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      // compare before predicting: a request accepted at this edge cannot finish here
      if (done) check_result();
      if (start && !busy) predict_socket_op();
    end
    pending = awaited_results.size();
  end

endmodule

FILE: verif/tb_udp_socket_table_engine_top.sv
// Testbench top for the UDP socket table engine: clock, reset, request stimulus
// and verdict. Depends on ust_pkg, ust_checker and udp_socket_table_engine_top.
module tb_udp_socket_table_engine_top;
  import ust_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [2:0]  op = '0;
  logic [15:0] proc_id = '0;
  logic [31:0] process_gen = '0;
  logic [31:0] handle = '0;
  logic [15:0] port = '0;
  logic [31:0] remote_ip = '0;
  logic [15:0] remote_port = '0;
  logic [15:0] length = '0;
  logic [15:0] capacity = '0;
  logic [15:0] send_tmo = '0;
  logic [3:0]  status;
  logic [31:0] new_handle;
  logic [3:0]  slot_index;
  logic [2:0]  queue_pos;
  logic [31:0] peer_ip;
  logic [15:0] peer_port;
  logic [15:0] local_port_out;
  logic [15:0] length_out;
  logic [4:0]  active_count;
  logic [7:0]  queued_count;
  logic [31:0] dropped_count;
  int fail_count;
  int pending;
  int cycle_count = 0;

  // sockets opened so far, as seen by the stimulus
  logic [31:0] open_handle[$];
  logic [15:0] open_pid[$];
  logic [31:0] open_pgen[$];

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [15:0] OWNER_PID [3] = '{16'd1, 16'd2, 16'hffff};
  localparam logic [31:0] OWNER_PGEN[3] = '{32'd1, 32'h8000_0000, 32'hffff_ffff};
  localparam logic [15:0] PORT_SET  [4] = '{16'd7, 16'd53, 16'd5000, 16'hffff};

  udp_socket_table_engine_top u_dut (.*);
  ust_checker u_checker (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("udp_socket_table_engine_top: mismatch");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    int roll;
    roll = $urandom_range(99);
    n = (roll < 60) ? 0 : (roll < 95) ? $urandom_range(4, 1) : $urandom_range(60, 20);
    repeat (n) @(posedge clk);
  endtask

  // issue one request; hold start until it is taken
  task automatic send_request(op_t o, logic [15:0] pid, logic [31:0] pgen, logic [31:0] h,
                              logic [15:0] prt, logic [31:0] rip, logic [15:0] rprt,
                              logic [15:0] len, logic [15:0] cap, logic [15:0] tmo);
    logic taken;
    idle_gap();
    @(posedge clk);
    start <= 1'b1;
    op <= o; proc_id <= pid; process_gen <= pgen; handle <= h; port <= prt;
    remote_ip <= rip; remote_port <= rprt; length <= len; capacity <= cap;
    send_tmo <= tmo;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    start <= 1'b0;
    if (o == OP_OPEN) begin
      // the previous result may still be on the ports at the accepting edge
      do @(posedge clk); while (!done);
      if (status == ST_OK) begin
        open_handle.push_back(new_handle);
        open_pid.push_back(pid);
        open_pgen.push_back(pgen);
      end
    end
  endtask

  task automatic forget_owner(logic [15:0] pid, logic [31:0] pgen);
    for (int i = open_handle.size() - 1; i >= 0; i--)
      if (open_pid[i] == pid && open_pgen[i] == pgen) begin
        open_handle.delete(i); open_pid.delete(i); open_pgen.delete(i);
      end
  endtask

  task automatic random_request();
    int i;
    int o;
    logic [31:0] h;
    logic [15:0] pid;
    logic [31:0] pgen;
    logic [15:0] prt;
    if ($urandom_range(9) == 0) begin
      // noise: every field free
      send_request(op_t'($urandom_range(7)), 16'($urandom), $urandom, $urandom,
                   16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
      if (op == OP_CLEANUP) forget_owner(proc_id, process_gen);
      return;
    end
    o = $urandom_range(99);
    prt = PORT_SET[$urandom_range(3)];
    if (open_handle.size() == 0 || o < 12) begin
      i = $urandom_range(2);
      send_request(OP_OPEN, OWNER_PID[i], OWNER_PGEN[i], 0, 0, 0, 0, 0, 0, 0);
      return;
    end
    i = $urandom_range(open_handle.size() - 1);
    h = open_handle[i]; pid = open_pid[i]; pgen = open_pgen[i];
    if ($urandom_range(19) == 0) h ^= 32'(1) << $urandom_range(31);
    if (o < 22)
      send_request(OP_BIND, pid, pgen, h, prt, 0, 0, 0, 0, 0);
    else if (o < 27) begin
      send_request(OP_CLOSE, pid, pgen, h, 0, 0, 0, 0, 0, 0);
      if (h == open_handle[i]) begin
        open_handle.delete(i); open_pid.delete(i); open_pgen.delete(i);
      end
    end else if (o < 29) begin
      send_request(OP_CLEANUP, pid, pgen, 0, 0, 0, 0, 0, 0, 0);
      forget_owner(pid, pgen);
    end else if (o < 60)
      send_request(OP_INGRESS, 0, 0, 0, prt, $urandom_range(32'hffffffff, 1),
                   16'($urandom_range(16'hffff, 1)), 16'($urandom_range(1500)), 0, 0);
    else if (o < 85)
      send_request(OP_RECV, pid, pgen, h, 0, 0, 0, 0, 16'($urandom_range(1600)),
                   16'($urandom));
    else if (o < 95)
      send_request(OP_SEND, pid, pgen, h, 0, $urandom_range(32'hffffffff, 1),
                   16'($urandom_range(16'hffff, 1)), 16'($urandom_range(1500)),
                   0, 16'($urandom_range(10100)));
    else
      send_request(OP_STATS, 0, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  initial begin
    logic [31:0] ha;
    logic [31:0] hb;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: each status but ST_NO_SLOT, and the field extremes
    send_request(OP_OPEN, 16'd0, 32'd5, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_OPEN, 16'd9, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_OPEN, 16'hffff, 32'hffffffff, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_OPEN, 16'd1, 32'd1, 0, 0, 0, 0, 0, 0, 0);
    ha = open_handle[0]; hb = open_handle[1];
    send_request(OP_BIND, 16'hffff, 32'hffffffff, ha, 16'd0, 0, 0, 0, 0, 0);
    send_request(OP_SEND, 16'hffff, 32'hffffffff, ha, 0, 32'd1, 16'd1, 16'd1472, 0, 16'd10000);
    send_request(OP_BIND, 16'hffff, 32'hffffffff, ha, 16'hffff, 0, 0, 0, 0, 0);
    send_request(OP_BIND, 16'hffff, 32'hffffffff, ha, 16'd53, 0, 0, 0, 0, 0);
    send_request(OP_BIND, 16'd1, 32'd1, hb, 16'hffff, 0, 0, 0, 0, 0);
    send_request(OP_BIND, 16'd1, 32'd1, 32'hffffffff, 16'd7, 0, 0, 0, 0, 0);
    send_request(OP_SEND, 16'hffff, 32'hffffffff, ha, 0, 32'd1, 16'd1, 16'd1472, 0, 16'd10001);
    send_request(OP_SEND, 16'hffff, 32'hffffffff, ha, 0, 32'hffffffff, 16'hffff, 16'd0, 0, 0);
    send_request(OP_INGRESS, 0, 0, 0, 16'hffff, 32'hffffffff, 16'hffff, 16'd1473, 0, 0);
    send_request(OP_INGRESS, 0, 0, 0, 16'd9, 32'd1, 16'd1, 16'd1, 0, 0);
    repeat (9)
      send_request(OP_INGRESS, 0, 0, 0, 16'hffff, 32'hffffffff, 16'hffff, 16'd1472, 0, 0);
    send_request(OP_RECV, 16'hffff, 32'hffffffff, ha, 0, 0, 0, 0, 16'd1471, 0);
    send_request(OP_RECV, 16'hffff, 32'hffffffff, ha, 0, 0, 0, 0, 16'hffff, 0);
    send_request(OP_RECV, 16'd1, 32'd1, hb, 0, 0, 0, 0, 16'hffff, 16'hffff);
    send_request(OP_STATS, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_CLOSE, 16'hffff, 32'hffffffff, ha, 0, 0, 0, 0, 0, 0);
    send_request(OP_CLOSE, 16'hffff, 32'hffffffff, ha, 0, 0, 0, 0, 0, 0);
    open_handle.delete(0); open_pid.delete(0); open_pgen.delete(0);

    for (int n = 0; n < 950; n++) begin
      if (n == 475) begin
        // let the checker count the last request before waiting on it
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_request();
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("udp_socket_table_engine_top: match");
    else
      $display("udp_socket_table_engine_top: mismatch");
    $finish;
  end

endmodule
